// File: rtl/bwq_pkg.sv
// Package for the wait queue with random wakeup: operation and status codes,
// default sizes and the cell control struct. No dependencies.
package bwq_pkg;
   localparam int unsigned DefDepth     = 16;
   localparam int unsigned DefProcBits  = 8;
   localparam int unsigned DefBlockBits = 10;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_COUNT  = 3'd3;
   localparam logic [2:0] OP_WAKEUP = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Control that the sequencer sends along the row of cells.
   typedef struct packed {
      logic shift;   // every cell at or after the drop point takes its right neighbour
      logic load;    // the tail cell takes the new entry
   } cell_ctl_type;
endpackage

// File: rtl/bwq_cell.sv
// One entry cell of the wait queue: holds a process and a block, takes its right
// neighbour's contents when the row closes a gap, and takes the new entry at the tail. Uses bwq_pkg.
module bwq_cell #(
   parameter int unsigned PROC_BITS  = bwq_pkg::DefProcBits,
   parameter int unsigned BLOCK_BITS = bwq_pkg::DefBlockBits
) (
   input  logic                    clock,
   input  bwq_pkg::cell_ctl_type   ctl,
   input  logic                    at_drop,   // this cell is at or after the drop point
   input  logic                    at_tail,   // this cell is the first free slot
   input  logic [PROC_BITS-1:0]    next_proc,
   input  logic [BLOCK_BITS-1:0]   next_block,
   input  logic [PROC_BITS-1:0]    new_proc,
   input  logic [BLOCK_BITS-1:0]   new_block,
   output logic [PROC_BITS-1:0]    proc_q,
   output logic [BLOCK_BITS-1:0]   block_q
);
   logic [PROC_BITS-1:0]  proc_ff, proc_in;
   logic [BLOCK_BITS-1:0] block_ff, block_in;

   always_comb begin
      proc_in  = proc_ff;
      block_in = block_ff;
      if (ctl.shift && at_drop) begin
         proc_in  = next_proc;
         block_in = next_block;
      end else if (ctl.load && at_tail) begin
         proc_in  = new_proc;
         block_in = new_block;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff  <= proc_in;
      block_ff <= block_in;
   end

   assign proc_q  = proc_ff;
   assign block_q = block_ff;
endmodule

// File: rtl/block_wait_queue_random_wakeup.sv
// Wait queue of (process, block) entries kept in arrival order, with wakeup
// of a randomly chosen waiter on a block.
// A request is taken when start is high and busy is low; busy then stays high
// until the response. The response shows on the rsp_ ports for one cycle,
// marked by rsp_valid; the receiver cannot hold it off.
// Insert and count go straight to the done state. Remove and search walk the row
// one cell per cycle. Wakeup walks the row once to count matches, reduces pick
// modulo the count one quotient bit per cycle, walks again to find the chosen
// entry and then closes the gap in a single shift of the cell row. One request
// at a time; the scan counter and the serial remainder unit step these walks.
// Reset clears the occupancy and the sequencer; the entry cells are not
// cleared, and only cells below the occupancy are ever read.
// The response occupancy is the count after the request.
module block_wait_queue_random_wakeup #(
   parameter int unsigned DEPTH      = bwq_pkg::DefDepth,
   parameter int unsigned PROC_BITS  = bwq_pkg::DefProcBits,
   parameter int unsigned BLOCK_BITS = bwq_pkg::DefBlockBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_op,
   input  logic [PROC_BITS-1:0]   req_proc_id,
   input  logic [BLOCK_BITS-1:0]  req_block_id,
   input  logic [15:0]            req_pick,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [PROC_BITS-1:0]   rsp_proc_out,
   output logic [BLOCK_BITS-1:0]  rsp_block_out,
   output logic [$clog2(DEPTH+1)-1:0] rsp_occupancy
);
   localparam int unsigned CW = $clog2(DEPTH+1);
   localparam int unsigned IW = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;   // search/remove walk, or wakeup counting walk
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_PICK = 3'd3;   // wakeup walk to the chosen match
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [PROC_BITS-1:0]  p_ff, p_in;
   logic [BLOCK_BITS-1:0] b_ff, b_in;
   logic [15:0]           pick_ff, pick_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         match_ff, match_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [4:0]            bit_ff, bit_in;
   logic [IW-1:0]         drop_ff, drop_in;
   logic                  valid_ff, valid_in;
   logic [1:0]            st_ff, st_in;
   logic [PROC_BITS-1:0]  po_ff, po_in;
   logic [BLOCK_BITS-1:0] bo_ff, bo_in;
   bwq_pkg::cell_ctl_type ctl;

   logic [PROC_BITS-1:0]  cp [DEPTH];
   logic [BLOCK_BITS-1:0] cb [DEPTH];
   logic [PROC_BITS-1:0]  cur_p;
   logic [BLOCK_BITS-1:0] cur_b;
   logic [CW:0]           rem_sh;

   assign cur_p = cp[idx_ff[IW-1:0]];
   assign cur_b = cb[idx_ff[IW-1:0]];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [PROC_BITS-1:0]  np;
         logic [BLOCK_BITS-1:0] nb;
         if (g == DEPTH-1) begin : g_last
            assign np = cp[g];
            assign nb = cb[g];
         end else begin : g_mid
            assign np = cp[g+1];
            assign nb = cb[g+1];
         end
         bwq_cell #(.PROC_BITS(PROC_BITS), .BLOCK_BITS(BLOCK_BITS)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .at_drop   (IW'(g) >= drop_ff),
            .at_tail   (CW'(g) == cnt_ff),
            .next_proc (np),
            .next_block(nb),
            .new_proc  (p_ff),
            .new_block (b_ff),
            .proc_q    (cp[g]),
            .block_q   (cb[g])
         );
      end
   endgenerate

   // Restoring remainder step: one quotient bit of pick per cycle.
   assign rem_sh = {rem_ff, pick_ff[bit_ff[3:0]]};

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  p_in = p_ff;  b_in = b_ff;
      pick_in = pick_ff;    cnt_in = cnt_ff; idx_in = idx_ff;
      match_in = match_ff;  rem_in = rem_ff; bit_in = bit_ff;
      drop_in = drop_ff;    valid_in = 1'b0;
      st_in = st_ff;        po_in = po_ff;   bo_in = bo_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_op;  p_in = req_proc_id;
               b_in = req_block_id;  pick_in = req_pick;
               idx_in = '0;  match_in = '0;
               st_in = bwq_pkg::ST_OK;  po_in = '0;  bo_in = '0;
               if (req_op == bwq_pkg::OP_REMOVE || req_op == bwq_pkg::OP_SEARCH ||
                   req_op == bwq_pkg::OP_WAKEUP)
                  state_in = S_SCAN;
               else
                  state_in = S_DONE;
               if (req_op == bwq_pkg::OP_INSERT && cnt_ff >= CW'(DEPTH))
                  st_in = bwq_pkg::ST_FULL;
            end
         end
         S_SCAN: begin
            if (idx_ff >= cnt_ff) begin
               if (op_ff == bwq_pkg::OP_WAKEUP && match_ff != '0) begin
                  state_in = S_MOD;  rem_in = '0;  bit_in = 5'd15;
               end else begin
                  st_in = bwq_pkg::ST_MISS;  state_in = S_DONE;
               end
            end else if (op_ff == bwq_pkg::OP_WAKEUP) begin
               if (cur_b == b_ff) match_in = match_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (cur_p == p_ff) begin
               if (op_ff == bwq_pkg::OP_SEARCH) bo_in = cur_b;
               else drop_in = idx_ff[IW-1:0];
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MOD: begin
            if (rem_sh >= {1'b0, match_ff}) rem_in = CW'(rem_sh - {1'b0, match_ff});
            else rem_in = rem_sh[CW-1:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd0) begin
               state_in = S_PICK;  idx_in = '0;
            end
         end
         S_PICK: begin
            if (cur_b == b_ff) begin
               if (rem_ff == '0) begin
                  po_in = cur_p;  bo_in = cur_b;
                  drop_in = idx_ff[IW-1:0];  state_in = S_DONE;
               end else begin
                  rem_in = rem_ff - 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
         end
         S_DONE: begin
            // Queue updates happen here so the drop point register is settled.
            if (op_ff == bwq_pkg::OP_INSERT && st_ff == bwq_pkg::ST_OK) begin
               ctl.load = 1'b1;  cnt_in = cnt_ff + 1'b1;
            end else if (st_ff == bwq_pkg::ST_OK &&
                         (op_ff == bwq_pkg::OP_REMOVE || op_ff == bwq_pkg::OP_WAKEUP)) begin
               ctl.shift = 1'b1;  cnt_in = cnt_ff - 1'b1;
            end
            valid_in = 1'b1;  state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  cnt_ff <= '0;  valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  cnt_ff <= cnt_in;  valid_ff <= valid_in;
      end
      op_ff <= op_in;  p_ff <= p_in;  b_ff <= b_in;  pick_ff <= pick_in;
      idx_ff <= idx_in;  match_ff <= match_in;  rem_ff <= rem_in;
      bit_ff <= bit_in;  drop_ff <= drop_in;
      st_ff <= st_in;  po_ff <= po_in;  bo_ff <= bo_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_status    = st_ff;
   assign rsp_proc_out  = po_ff;
   assign rsp_block_out = bo_ff;
   assign rsp_occupancy = cnt_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("occupancy beyond depth");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |-> (rem_ff < match_ff)) else $error("pick beyond matches");
endmodule
